>>> sv/srtf_pkg.sv
`timescale 1ns / 1ps

package srtf_pkg;

  // Defaults for the top-level parameters.
  localparam int unsigned NumSlotsDefault = 8;
  localparam int unsigned TimeBitsDefault = 16;

  // Fixed field widths and limits of the result.
  localparam logic [23:0] SUM_MAX     = 24'hFF_FFFF;
  localparam logic [15:0] FIELD16_MAX = 16'hFFFF;
  localparam logic [3:0]  COUNT_MAX   = 4'hF;

  // Request command codes.
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // Sequencer states of the top level.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EXEC,
    ST_SUM
  } state_e;

  // Per-cell strobes from the sequencer.
  typedef struct packed {
    logic load;
    logic dec;
  } cell_ctrl_t;

endpackage

>>> sv/srtf_if.sv
`timescale 1ns / 1ps

// Request channel: one load or one tick per request.
interface srtf_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [2:0]  slot;
  logic [15:0] arrival;
  logic [15:0] burst;
  logic [7:0]  prio;

  modport source (output valid, command, slot, arrival, burst, prio, input ready);
  modport sink   (input valid, command, slot, arrival, burst, prio, output ready);
endinterface

// Result channel: one result per request.
interface srtf_out_if;
  logic        valid;
  logic        ready;
  logic        idle;
  logic [2:0]  chosen;
  logic        finished;
  logic [15:0] finish_time;
  logic [15:0] proc_wait;
  logic [15:0] proc_turnaround;
  logic [23:0] total_wait;
  logic [23:0] total_turnaround;
  logic [3:0]  done_count;

  modport source (output valid, idle, chosen, finished, finish_time, proc_wait,
                  proc_turnaround, total_wait, total_turnaround, done_count,
                  input ready);
  modport sink   (input valid, idle, chosen, finished, finish_time, proc_wait,
                  proc_turnaround, total_wait, total_turnaround, done_count,
                  output ready);
endinterface

>>> sv/srtf_priority_tiebreak_scheduler.sv
`timescale 1ns / 1ps
// Sequence: a load request goes from idle to the sum state; a tick request goes through the
// scan, execute and sum states, the candidate passing through the row of slot cells one
// cell a cycle during the scan. The sum state holds while the result register is stalled.
// A new request is taken only in the idle state, after the last result has been issued.
// Reset: asynchronous, active low; all slots empty, time, totals and count at zero.
module srtf_priority_tiebreak_scheduler import srtf_pkg::*; #(
  parameter int unsigned NUM_SLOTS = NumSlotsDefault,
  parameter int unsigned TIME_BITS = TimeBitsDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  srtf_in_if.sink    in_i,
  srtf_out_if.source out_o
);

  localparam int unsigned IDX_BITS = $clog2(NUM_SLOTS);
  localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

  state_e st_q, st_d;
  logic [IDX_BITS-1:0]  cnt_q;
  logic [TIME_BITS-1:0] now_q, end_q, turn_q, len_q;
  logic                 res_tick_q, res_found_q, res_fin_q;
  logic [IDX_BITS-1:0]  res_idx_q;
  logic [23:0]          wait_sum_q, turn_sum_q;
  logic [3:0]           count_q;

  logic        in_acc, is_load, is_tick, slot_ok, out_free;
  logic [31:0] arr32, bur32;
  logic [TIME_BITS-1:0] ld_arrive, ld_burst;

  // Candidate chain between cells; entry zero is the empty candidate.
  logic                 c_found  [NUM_SLOTS+1];
  logic [TIME_BITS-1:0] c_rem    [NUM_SLOTS+1];
  logic [7:0]           c_prio   [NUM_SLOTS+1];
  logic [IDX_BITS-1:0]  c_idx    [NUM_SLOTS+1];
  logic [TIME_BITS-1:0] c_arrive [NUM_SLOTS+1];
  logic [TIME_BITS-1:0] c_len    [NUM_SLOTS+1];

  // Saturate a time value to the 16-bit result field.
  function automatic logic [15:0] clip16(input logic [TIME_BITS-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return (w > 32'(FIELD16_MAX)) ? FIELD16_MAX : w[15:0];
  endfunction

  // Saturating add onto a 24-bit total.
  function automatic logic [23:0] sat_add(input logic [23:0] s,
                                          input logic [TIME_BITS-1:0] v);
    logic [32:0] t;
    t = 33'(s) + 33'(v);
    return (t > 33'(SUM_MAX)) ? SUM_MAX : t[23:0];
  endfunction

  // Request decode and load data masked to the time width.
  always_comb begin
    in_acc    = in_i.valid && in_i.ready;
    is_load   = in_acc && (in_i.command == CMD_LOAD);
    is_tick   = in_acc && (in_i.command == CMD_TICK);
    slot_ok   = 32'(in_i.slot) < NUM_SLOTS;
    arr32     = 32'(in_i.arrival);
    bur32     = 32'(in_i.burst);
    ld_arrive = arr32[TIME_BITS-1:0];
    ld_burst  = bur32[TIME_BITS-1:0];
    out_free  = !out_o.valid || out_o.ready;
  end

  assign in_i.ready = (st_q == ST_IDLE);

  assign c_found[0]  = 1'b0;
  assign c_rem[0]    = '0;
  assign c_prio[0]   = '0;
  assign c_idx[0]    = '0;
  assign c_arrive[0] = '0;
  assign c_len[0]    = '0;

  // Row of slot cells.
  for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
    cell_ctrl_t ctrl;

    always_comb begin
      ctrl.load = is_load && slot_ok && (32'(in_i.slot) == g);
      ctrl.dec  = (st_q == ST_EXEC) && c_found[NUM_SLOTS] &&
                  (32'(c_idx[NUM_SLOTS]) == g);
    end

    srtf_cell #(
      .TIME_BITS (TIME_BITS),
      .IDX_BITS  (IDX_BITS),
      .CELL_IDX  (g)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .ld_arrive_i (ld_arrive),
      .ld_burst_i  (ld_burst),
      .ld_prio_i   (in_i.prio),
      .now_i       (now_q),
      .found_i     (c_found[g]),
      .rem_i       (c_rem[g]),
      .prio_i      (c_prio[g]),
      .idx_i       (c_idx[g]),
      .arrive_i    (c_arrive[g]),
      .len_i       (c_len[g]),
      .found_o     (c_found[g+1]),
      .rem_o       (c_rem[g+1]),
      .prio_o      (c_prio[g+1]),
      .idx_o       (c_idx[g+1]),
      .arrive_o    (c_arrive[g+1]),
      .len_o       (c_len[g+1])
    );
  end

  // Sequencer next state.
  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE: begin
        if (is_tick) st_d = ST_SCAN;
        else if (is_load) st_d = ST_SUM;
      end
      ST_SCAN: begin
        if (cnt_q == IDX_BITS'(NUM_SLOTS - 1)) st_d = ST_EXEC;
      end
      ST_EXEC: st_d = ST_SUM;
      ST_SUM: begin
        if (out_free) st_d = ST_IDLE;
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  // Scan counter: counts through the cells in the scan state, cleared otherwise.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (st_q == ST_SCAN) begin
      cnt_q <= cnt_q + IDX_BITS'(1);
    end else begin
      cnt_q <= '0;
    end
  end

  // Time, per-request result staging and running totals.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q       <= '0;
      end_q       <= '0;
      res_tick_q  <= 1'b0;
      res_found_q <= 1'b0;
      res_fin_q   <= 1'b0;
      wait_sum_q  <= '0;
      turn_sum_q  <= '0;
      count_q     <= '0;
    end else begin
      case (st_q)
        ST_IDLE: begin
          if (in_acc) begin
            res_tick_q  <= is_tick;
            res_found_q <= 1'b0;
            res_fin_q   <= 1'b0;
            end_q       <= (now_q == TIME_MAX) ? TIME_MAX : now_q + TIME_BITS'(1);
          end
        end
        ST_EXEC: begin
          res_found_q <= c_found[NUM_SLOTS];
          res_fin_q   <= c_found[NUM_SLOTS] && (c_rem[NUM_SLOTS] == TIME_BITS'(1));
          now_q       <= end_q;
        end
        ST_SUM: begin
          if (out_free && res_fin_q) begin
            wait_sum_q <= sat_add(wait_sum_q, (turn_q > len_q) ? turn_q - len_q : '0);
            turn_sum_q <= sat_add(turn_sum_q, turn_q);
            count_q    <= (count_q == COUNT_MAX) ? COUNT_MAX : count_q + 4'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // Chosen slot's figures, taken from the end of the chain.
  always_ff @(posedge clk_i) begin
    if (st_q == ST_EXEC) begin
      res_idx_q <= c_idx[NUM_SLOTS];
      turn_q    <= end_q - c_arrive[NUM_SLOTS];
      len_q     <= c_len[NUM_SLOTS];
    end
  end

  // Output register.
  logic [TIME_BITS-1:0] wt;
  logic [31:0]          idx32;

  always_comb begin
    wt    = (turn_q > len_q) ? turn_q - len_q : '0;
    idx32 = 32'(res_idx_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_o.valid <= 1'b0;
    end else if (st_q == ST_SUM && out_free) begin
      out_o.valid <= 1'b1;
    end else if (out_o.ready) begin
      out_o.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == ST_SUM && out_free) begin
      out_o.idle             <= !res_found_q;
      out_o.chosen           <= res_found_q ? idx32[2:0] : 3'd0;
      out_o.finished         <= res_fin_q;
      out_o.finish_time      <= res_tick_q ? clip16(end_q) : 16'd0;
      out_o.proc_wait        <= res_fin_q ? clip16(wt) : 16'd0;
      out_o.proc_turnaround  <= res_fin_q ? clip16(turn_q) : 16'd0;
      out_o.total_wait       <= res_fin_q ? sat_add(wait_sum_q, wt) : wait_sum_q;
      out_o.total_turnaround <= res_fin_q ? sat_add(turn_sum_q, turn_q) : turn_sum_q;
      out_o.done_count       <= res_fin_q ?
                                ((count_q == COUNT_MAX) ? COUNT_MAX : count_q + 4'd1) :
                                count_q;
    end
  end

endmodule

>>> sv/srtf_cell.sv
`timescale 1ns / 1ps

module srtf_cell import srtf_pkg::*; #(
  parameter int unsigned TIME_BITS = TimeBitsDefault,
  parameter int unsigned IDX_BITS  = 3,
  parameter int unsigned CELL_IDX  = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cell_ctrl_t           ctrl_i,
  input  logic [TIME_BITS-1:0] ld_arrive_i,
  input  logic [TIME_BITS-1:0] ld_burst_i,
  input  logic [7:0]           ld_prio_i,
  input  logic [TIME_BITS-1:0] now_i,
  // Best candidate so far, from the previous cell.
  input  logic                 found_i,
  input  logic [TIME_BITS-1:0] rem_i,
  input  logic [7:0]           prio_i,
  input  logic [IDX_BITS-1:0]  idx_i,
  input  logic [TIME_BITS-1:0] arrive_i,
  input  logic [TIME_BITS-1:0] len_i,
  // Best candidate including this cell, registered.
  output logic                 found_o,
  output logic [TIME_BITS-1:0] rem_o,
  output logic [7:0]           prio_o,
  output logic [IDX_BITS-1:0]  idx_o,
  output logic [TIME_BITS-1:0] arrive_o,
  output logic [TIME_BITS-1:0] len_o
);

  logic [TIME_BITS-1:0] arrive_q, rem_q, len_q;
  logic [7:0]           prio_q;
  logic                 eligible, take;

  // Slot state: written by a load, decremented when this slot runs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arrive_q <= '0;
      rem_q    <= '0;
      len_q    <= '0;
      prio_q   <= '0;
    end else if (ctrl_i.load) begin
      arrive_q <= ld_arrive_i;
      rem_q    <= ld_burst_i;
      len_q    <= ld_burst_i;
      prio_q   <= ld_prio_i;
    end else if (ctrl_i.dec) begin
      rem_q <= rem_q - TIME_BITS'(1);
    end
  end

  // A slot takes over only when strictly better, so lower indices win full ties.
  always_comb begin
    eligible = (arrive_q <= now_i) && (rem_q != '0);
    take     = eligible && (!found_i || (rem_q < rem_i) ||
                            ((rem_q == rem_i) && (prio_q < prio_i)));
  end

  // Hand the running best on to the next cell.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_o <= 1'b0;
    end else begin
      found_o <= found_i || take;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      rem_o    <= rem_q;
      prio_o   <= prio_q;
      idx_o    <= IDX_BITS'(CELL_IDX);
      arrive_o <= arrive_q;
      len_o    <= len_q;
    end else begin
      rem_o    <= rem_i;
      prio_o   <= prio_i;
      idx_o    <= idx_i;
      arrive_o <= arrive_i;
      len_o    <= len_i;
    end
  end

endmodule

>>> sv/srtf_checker.sv
`timescale 1ns / 1ps

module srtf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        out_idle_i,
  input logic [2:0]  out_chosen_i,
  input logic        out_finished_i,
  input logic [15:0] out_finish_time_i,
  input logic [15:0] out_proc_wait_i,
  input logic [15:0] out_proc_turnaround_i
);

  // The block works on one request at a time.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("request accepted while the previous one is still at work");

  // A stalled result is held.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(out_chosen_i) &&
                                       $stable(out_finish_time_i)))
    else $error("stalled result changed");

  // An idle result carries no run and no completion.
  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_idle_i) |-> (!out_finished_i && out_chosen_i == 3'd0 &&
                                     out_proc_wait_i == 16'd0))
    else $error("idle result reports a run");

  // A slot that ran did so in a tick, so time has advanced.
  a_run_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_idle_i) |-> (out_finish_time_i != 16'd0))
    else $error("run reported with zero finish time");

  // Waiting time never exceeds turnaround time.
  a_wait_le_turn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_proc_wait_i <= out_proc_turnaround_i))
    else $error("waiting time above turnaround time");

endmodule

bind srtf_priority_tiebreak_scheduler srtf_checker u_srtf_checker (
  .clk_i                 (clk_i),
  .rst_ni                (rst_ni),
  .in_valid_i            (in_i.valid),
  .in_ready_i            (in_i.ready),
  .out_valid_i           (out_o.valid),
  .out_ready_i           (out_o.ready),
  .out_idle_i            (out_o.idle),
  .out_chosen_i          (out_o.chosen),
  .out_finished_i        (out_o.finished),
  .out_finish_time_i     (out_o.finish_time),
  .out_proc_wait_i       (out_o.proc_wait),
  .out_proc_turnaround_i (out_o.proc_turnaround)
);

>>> verif/srtf_priority_tiebreak_scheduler_tb.sv
`timescale 1ns / 1ps

module srtf_priority_tiebreak_scheduler_tb;
  import srtf_pkg::*;

  // One request as the sender presents it.
  typedef struct packed {
    logic        command;
    logic [2:0]  slot;
    logic [15:0] arrival;
    logic [15:0] burst;
    logic [7:0]  prio;
  } sched_request_t;

  // One result as the scheduler reports it.
  typedef struct packed {
    logic        idle;
    logic [2:0]  chosen;
    logic        finished;
    logic [15:0] finish_time;
    logic [15:0] proc_wait;
    logic [15:0] proc_turnaround;
    logic [23:0] total_wait;
    logic [23:0] total_turnaround;
    logic [3:0]  done_count;
  } sched_result_t;

  localparam logic [15:0] TimeLimit = 16'hFFFF;

  logic clk_i;
  logic rst_ni = 1'b0;

  srtf_in_if  req_if ();
  srtf_out_if res_if ();

  srtf_priority_tiebreak_scheduler dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (res_if)
  );

  // Predicted process table, clock and running totals.
  logic [15:0] arrive_tbl [NumSlotsDefault] = '{default: '0};
  logic [15:0] left_tbl   [NumSlotsDefault] = '{default: '0};
  logic [15:0] length_tbl [NumSlotsDefault] = '{default: '0};
  logic [7:0]  rank_tbl   [NumSlotsDefault] = '{default: '0};
  logic [15:0] sched_now   = '0;
  logic [23:0] wait_total  = '0;
  logic [23:0] turn_total  = '0;
  logic [3:0]  completions = '0;

  sched_result_t pending_results [$];
  int unsigned   mismatches = 0;
  bit            idling_on  = 1'b1;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Generous ceiling on the whole run.
  initial begin
    #2ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Works out the result of one accepted request and updates the predicted state.
  task automatic predict_schedule(input sched_request_t req, output sched_result_t res);
    logic [15:0] end_t;
    logic [15:0] turn;
    logic [15:0] lag;
    logic [24:0] sum;
    int unsigned best;
    bit          found;
    res = '0;
    res.idle = 1'b1;
    if (req.command == CMD_LOAD) begin
      arrive_tbl[req.slot] = req.arrival;
      left_tbl[req.slot]   = req.burst;
      length_tbl[req.slot] = req.burst;
      rank_tbl[req.slot]   = req.prio;
    end else begin
      end_t = (sched_now == TimeLimit) ? TimeLimit : sched_now + 16'd1;
      found = 1'b0;
      best  = 0;
      // Shortest remaining time among arrived slots, then priority, then index.
      for (int i = 0; i < NumSlotsDefault; i++) begin
        if (arrive_tbl[i] <= sched_now && left_tbl[i] != '0) begin
          if (!found || left_tbl[i] < left_tbl[best] ||
              (left_tbl[i] == left_tbl[best] && rank_tbl[i] < rank_tbl[best])) begin
            best  = i;
            found = 1'b1;
          end
        end
      end
      if (found) begin
        res.idle   = 1'b0;
        res.chosen = 3'(best);
        left_tbl[best] = left_tbl[best] - 16'd1;
        if (left_tbl[best] == '0) begin
          turn = end_t - arrive_tbl[best];
          // A saturated clock can leave the turnaround shorter than the burst.
          lag  = (turn > length_tbl[best]) ? turn - length_tbl[best] : '0;
          res.finished        = 1'b1;
          res.proc_wait       = lag;
          res.proc_turnaround = turn;
          sum = wait_total + lag;
          wait_total = (sum > SUM_MAX) ? SUM_MAX : sum[23:0];
          sum = turn_total + turn;
          turn_total = (sum > SUM_MAX) ? SUM_MAX : sum[23:0];
          if (completions != COUNT_MAX) completions = completions + 4'd1;
        end
      end
      res.finish_time = end_t;
      sched_now = end_t;
    end
    res.total_wait       = wait_total;
    res.total_turnaround = turn_total;
    res.done_count       = completions;
  endtask

  // Presents one request, waits for its acceptance and records its expected result.
  task automatic issue_request(input sched_request_t req);
    sched_result_t res;
    if (idling_on && $urandom_range(0, 3) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    req_if.valid   <= 1'b1;
    req_if.command <= req.command;
    req_if.slot    <= req.slot;
    req_if.arrival <= req.arrival;
    req_if.burst   <= req.burst;
    req_if.prio    <= req.prio;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    predict_schedule(req, res);
    pending_results.push_back(res);
  endtask

  task automatic load_slot(input logic [2:0] slot, input logic [15:0] arrival,
                           input logic [15:0] burst, input logic [7:0] prio);
    sched_request_t req;
    req = '{command: CMD_LOAD, slot: slot, arrival: arrival, burst: burst, prio: prio};
    issue_request(req);
  endtask

  // The other fields of a tick are ignored, so they carry random values.
  task automatic run_tick();
    sched_request_t req;
    req = '{command: CMD_TICK, slot: 3'($urandom), arrival: 16'($urandom),
            burst: 16'($urandom), prio: 8'($urandom)};
    issue_request(req);
  endtask

  // Mostly near-term arrivals and short bursts, with some far arrivals and empty or
  // huge bursts mixed in.
  task automatic random_load();
    int          pick;
    int          ahead;
    logic [15:0] arrival;
    logic [15:0] burst;
    logic [7:0]  prio;
    pick = $urandom_range(0, 19);
    if (pick < 14) begin
      ahead   = int'(sched_now) + $urandom_range(0, 15);
      arrival = (ahead > 65535) ? TimeLimit : 16'(ahead);
    end else if (pick < 17) begin
      arrival = 16'($urandom_range(0, int'(sched_now)));
    end else begin
      arrival = 16'($urandom);
    end
    pick = $urandom_range(0, 19);
    if (pick < 16) burst = 16'($urandom_range(1, 10));
    else if (pick < 18) burst = '0;
    else burst = 16'($urandom);
    prio = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 3)) : 8'($urandom);
    load_slot(3'($urandom), arrival, burst, prio);
  endtask

  function automatic string fmt_result(sched_result_t r);
    return $sformatf({"idle=%0d chosen=%0d fin=%0d ftime=%0d wait=%0d turn=%0d",
                      " twait=%0d tturn=%0d done=%0d"},
                     r.idle, r.chosen, r.finished, r.finish_time, r.proc_wait,
                     r.proc_turnaround, r.total_wait, r.total_turnaround, r.done_count);
  endfunction

  // Ticks on an empty table run nothing but still advance time.
  task automatic test_idle_ticks();
    repeat (2) run_tick();
  endtask

  // Field extremes: a slot that never arrives and a slot with no work.
  task automatic test_load_extremes();
    load_slot(3'd7, 16'hFFFF, 16'hFFFF, 8'hFF);
    load_slot(3'd0, 16'h0000, 16'h0000, 8'h00);
    run_tick();
    load_slot(3'd7, 16'h0000, 16'h0000, 8'h00);
    run_tick();
  endtask

  // Equal remaining times settle by priority then index; a late short job preempts.
  task automatic test_tie_breaks();
    logic [15:0] base;
    base = sched_now;
    load_slot(3'd3, base, 16'd2, 8'd5);
    load_slot(3'd1, base, 16'd2, 8'd5);
    load_slot(3'd6, base, 16'd2, 8'd1);
    load_slot(3'd2, 16'd0, 16'd3, 8'd0);
    load_slot(3'd4, base + 16'd2, 16'd1, 8'd9);
    repeat (12) run_tick();
  endtask

  // Batches of loads followed by runs of ticks, with stray loads mid-run.
  task automatic test_random_traffic();
    int sent;
    sent = 0;
    while (sent < 320) begin
      repeat ($urandom_range(1, 6)) begin
        random_load();
        sent++;
      end
      repeat ($urandom_range(4, 40)) begin
        if ($urandom_range(0, 9) == 0) random_load();
        else run_tick();
        sent++;
      end
    end
  endtask

  // Requests follow one another with no idling on either side from here on.
  task automatic test_back_to_back();
    idling_on = 1'b0;
    load_slot(3'd0, sched_now, 16'd3, 8'h02);
    load_slot(3'd5, sched_now + 16'd1, 16'd2, 8'h01);
    repeat (8) run_tick();
  endtask

  // Single-tick jobs arriving at zero finish in turn and push the completion count
  // into saturation.
  task automatic test_total_limits();
    repeat (40) begin
      load_slot(3'($urandom), 16'h0000, 16'd1, 8'($urandom));
      run_tick();
    end
  endtask

  // Result sink: random stalls and checking against the oldest expectation.
  initial begin : result_check
    sched_result_t got;
    sched_result_t want;
    string         diffs;
    int            stall_left;
    stall_left   = 0;
    res_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
        got = '{idle: res_if.idle, chosen: res_if.chosen, finished: res_if.finished,
                finish_time: res_if.finish_time, proc_wait: res_if.proc_wait,
                proc_turnaround: res_if.proc_turnaround, total_wait: res_if.total_wait,
                total_turnaround: res_if.total_turnaround, done_count: res_if.done_count};
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result with no request pending: %s", $realtime, fmt_result(got));
        end else begin
          want  = pending_results.pop_front();
          diffs = "";
          if (got.idle !== want.idle) diffs = {diffs, " idle"};
          if (got.chosen !== want.chosen) diffs = {diffs, " chosen"};
          if (got.finished !== want.finished) diffs = {diffs, " finished"};
          if (got.finish_time !== want.finish_time) diffs = {diffs, " finish_time"};
          if (got.proc_wait !== want.proc_wait) diffs = {diffs, " proc_wait"};
          if (got.proc_turnaround !== want.proc_turnaround) diffs = {diffs, " proc_turnaround"};
          if (got.total_wait !== want.total_wait) diffs = {diffs, " total_wait"};
          if (got.total_turnaround !== want.total_turnaround)
            diffs = {diffs, " total_turnaround"};
          if (got.done_count !== want.done_count) diffs = {diffs, " done_count"};
          if (diffs != "") begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: mismatch in%s", $realtime, diffs);
              $display("  expected %s", fmt_result(want));
              $display("  actual   %s", fmt_result(got));
            end
          end
        end
      end
      if (stall_left == 0 && idling_on && $urandom_range(0, 7) == 0)
        stall_left = $urandom_range(1, 9);
      if (stall_left != 0) begin
        res_if.ready <= 1'b0;
        stall_left--;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    req_if.valid   = 1'b0;
    req_if.command = CMD_LOAD;
    req_if.slot    = '0;
    req_if.arrival = '0;
    req_if.burst   = '0;
    req_if.prio    = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_idle_ticks();
    test_load_extremes();
    test_tie_breaks();
    test_random_traffic();
    test_back_to_back();
    test_total_limits();

    req_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (2 * NumSlotsDefault + 8) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> files.f
sv/srtf_pkg.sv
sv/srtf_if.sv
sv/srtf_cell.sv
sv/srtf_priority_tiebreak_scheduler.sv
sv/srtf_checker.sv
verif/srtf_priority_tiebreak_scheduler_tb.sv
